// ===== sv/lcas_pkg.sv =====
// Shared types and constants for the Life grid step block.
// No dependencies; imported by the top level.
package lcas_pkg;

   localparam int COORD_W       = 6;
   localparam int POP_W         = 13;
   localparam int GRID_ROWS_DEF = 64;
   localparam int GRID_COLS_DEF = 64;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_SET     = 2'd1;
   localparam logic [1:0] CMD_ADVANCE = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   localparam logic [3:0] SURVIVE_CNT = 4'd2;
   localparam logic [3:0] BIRTH_CNT   = 4'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [COORD_W-1:0] row_index;
      logic [COORD_W-1:0] col_index;
   } req_type;

   typedef struct packed {
      logic             cell_alive;
      logic [POP_W-1:0] population;
   } rsp_type;

endpackage

// ===== sv/lcas_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lcas_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/life_cellular_automaton_step_top.sv =====
// Top level of the Life grid step block (B3/S23, bounded grid).
// Depends on lcas_pkg and lcas_ram.
//
//  channel | direction | payload          | handshake
//  req_    | in        | lcas_pkg::req_type | req_valid / req_ready
//  rsp_    | out       | lcas_pkg::rsp_type | rsp_valid / rsp_ready
//
// Clear goes straight to the result; set and read look up the addressed row (not
// when the address is off the grid); advance sweeps every row through the single
// read port of the grid RAM and then drains the population count pipeline.
// One word is worked at a time; a finished word waits in the rsp_ register
// while the next req_ word is taken. Grid rows carry valid bits that reset and
// clear drop at once, so no clearing pass is needed.
module life_cellular_automaton_step_top #(
   parameter int GRID_ROWS = lcas_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = lcas_pkg::GRID_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcas_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcas_pkg::rsp_type rsp_data
);

   import lcas_pkg::*;

   localparam int RW   = $clog2(GRID_ROWS);
   localparam int CW   = $clog2(GRID_COLS);
   localparam int CNTW = RW + 1;
   localparam int NCH  = (GRID_COLS + 7) / 8;
   localparam int PADW = NCH * 8;
   localparam int SW   = $clog2(GRID_COLS + 1);

   localparam logic [CNTW-1:0] ROWS_CNT = CNTW'(GRID_ROWS);
   localparam logic [CNTW-1:0] LAST_CNT = CNTW'(GRID_ROWS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic                 alive_ff, alive_in;
   logic [POP_W-1:0]     pop_ff, pop_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [GRID_COLS-1:0] prev_ff, prev_in;
   logic [GRID_COLS-1:0] cur_ff, cur_in;
   logic [GRID_ROWS-1:0] vld_ff, vld_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 a_vld_ff;
   logic [GRID_COLS-1:0] nrow_ff;
   logic                 b_vld_ff;
   logic [3:0]           chk_ff [NCH];
   logic [3:0]           chk_in [NCH];
   logic [POP_W-1:0]     acc_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 req_take;
   logic                 in_ok;
   logic [8:0]           row_ext, col_ext;
   logic [RW-1:0]        rd_addr, wr_addr;
   logic [GRID_COLS-1:0] rd_data, rd_row, next_row, new_row, wr_data, col_bit;
   logic                 wr_en;
   logic                 sweep_wr;
   logic                 cell_now;
   logic [CNTW-1:0]      wr_cnt;
   logic [SW-1:0]        row_sum;

   lcas_ram #(
      .DATA_W (GRID_COLS),
      .DEPTH  (GRID_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign row_ext   = 9'(req_data.row_index);
   assign col_ext   = 9'(req_data.col_index);
   assign in_ok     = (row_ext < 9'(GRID_ROWS)) && (col_ext < 9'(GRID_COLS));

   assign rd_row   = rd_vld_ff ? rd_data : '0;
   assign next_row = (cnt_ff <= ROWS_CNT) ? rd_row : '0;
   assign cell_now = rd_row[col_ff];
   assign sweep_wr = (state_ff == ST_SWEEP) && (cnt_ff >= CNTW'(2));
   assign wr_cnt   = cnt_ff - CNTW'(2);

   // next generation of the middle row of the window
   always_comb begin
      logic [GRID_COLS+1:0] p_pad;
      logic [GRID_COLS+1:0] c_pad;
      logic [GRID_COLS+1:0] n_pad;
      logic [3:0]           nb;
      p_pad = {1'b0, prev_ff, 1'b0};
      c_pad = {1'b0, cur_ff, 1'b0};
      n_pad = {1'b0, next_row, 1'b0};
      new_row = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         nb = 4'(p_pad[c]) + 4'(p_pad[c+1]) + 4'(p_pad[c+2])
            + 4'(c_pad[c]) + 4'(c_pad[c+2])
            + 4'(n_pad[c]) + 4'(n_pad[c+1]) + 4'(n_pad[c+2]);
         new_row[c] = (nb == BIRTH_CNT) || ((nb == SURVIVE_CNT) && cur_ff[c]);
      end
   end

   always_comb begin
      col_bit = '0;
      col_bit[col_ff] = 1'b1;
   end

   // read port select
   always_comb begin
      rd_addr = '0;
      if (req_take && in_ok) begin
         rd_addr = row_ext[RW-1:0];
      end else if ((state_ff == ST_SWEEP) && (cnt_ff < ROWS_CNT)) begin
         rd_addr = cnt_ff[RW-1:0];
      end
      rd_vld_in = vld_ff[rd_addr];
   end

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = row_ff;
      wr_data = rd_row | col_bit;
      if (sweep_wr) begin
         wr_en   = 1'b1;
         wr_addr = wr_cnt[RW-1:0];
         wr_data = new_row;
      end else if ((state_ff == ST_LOOK) && (cmd_ff == CMD_SET) && !cell_now) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      alive_in     = alive_ff;
      pop_in       = pop_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in   = req_data.command;
               row_in   = row_ext[RW-1:0];
               col_in   = col_ext[CW-1:0];
               alive_in = 1'b0;
               cnt_in   = '0;
               prev_in  = '0;
               cur_in   = '0;
               case (req_data.command)
                  CMD_CLEAR: begin
                     vld_in   = '0;
                     pop_in   = '0;
                     state_in = ST_DONE;
                  end
                  CMD_ADVANCE: begin
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = in_ok ? ST_LOOK : ST_DONE;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (cmd_ff == CMD_SET) begin
               if (!cell_now) begin
                  pop_in = pop_ff + POP_W'(1);
               end
            end else begin
               alive_in = cell_now;
            end
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff != '0) begin
               prev_in = cur_ff;
               cur_in  = next_row;
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!a_vld_ff && !b_vld_ff) begin
               pop_in   = acc_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.cell_alive = alive_ff;
               rsp_data_in.population = pop_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // population count of each new row, in byte groups
   always_comb begin
      logic [PADW-1:0] pad;
      pad = PADW'(nrow_ff);
      for (int i = 0; i < NCH; i++) begin
         chk_in[i] = '0;
         for (int j = 0; j < 8; j++) begin
            chk_in[i] = chk_in[i] + 4'(pad[i*8+j]);
         end
      end
   end

   always_comb begin
      row_sum = '0;
      for (int i = 0; i < NCH; i++) begin
         row_sum = row_sum + SW'(chk_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pop_ff       <= '0;
         vld_ff       <= '0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pop_ff       <= pop_in;
         vld_ff       <= vld_in;
         a_vld_ff     <= sweep_wr;
         b_vld_ff     <= a_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      alive_ff    <= alive_in;
      cnt_ff      <= cnt_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      rd_vld_ff   <= rd_vld_in;
      nrow_ff     <= new_row;
      chk_ff      <= chk_in;
      rsp_data_ff <= rsp_data_in;
      if (req_take) begin
         acc_ff <= '0;
      end else if (b_vld_ff) begin
         acc_ff <= acc_ff + POP_W'(row_sum);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_sweep_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (sweep_wr && (cnt_ff < ROWS_CNT)) |-> (wr_addr != rd_addr))
      else $error("sweep writes the row being read");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("second word taken while one is in work");

   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result dropped while output slot is full");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && (state_in == ST_DONE)) |-> (!a_vld_ff && !b_vld_ff))
      else $error("population taken before count pipeline is empty");

endmodule
